>>> design/cmbperm_pkg.sv
package cmbperm_pkg;

  localparam int unsigned MAX_N     = 20;
  localparam int unsigned N_W       = 5;
  localparam int unsigned COUNT_W   = 62;
  localparam int unsigned PROD_W    = COUNT_W + N_W;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIGIT_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned PC_W      = 3;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_CHECK,
    DP_MUL,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_REQ,
    JMP_BAD,
    JMP_LOOP_END,
    JMP_PERM,
    JMP_DIV_MORE,
    JMP_OUT_BUSY
  } jmp_t;

  typedef struct packed {
    dp_op_t op;
    jmp_t   jmp;
    pc_t    target;
  } uword_t;

  typedef struct packed {
    logic req;
    logic bad;
    logic loop_end;
    logic perm;
    logic div_more;
    logic out_busy;
  } dp_status_t;

  localparam pc_t STEP_IDLE     = 3'd0;
  localparam pc_t STEP_CHECK    = 3'd1;
  localparam pc_t STEP_LOOP     = 3'd2;
  localparam pc_t STEP_MUL      = 3'd3;
  localparam pc_t STEP_DIV_INIT = 3'd4;
  localparam pc_t STEP_DIV_STEP = 3'd5;
  localparam pc_t STEP_DIV_END  = 3'd6;
  localparam pc_t STEP_EMIT     = 3'd7;

  // control store: falling product, each factor followed by an exact divide for combinations
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:     w = '{op: DP_LOAD,     jmp: JMP_NO_REQ,   target: STEP_IDLE};
      STEP_CHECK:    w = '{op: DP_CHECK,    jmp: JMP_BAD,      target: STEP_EMIT};
      STEP_LOOP:     w = '{op: DP_NOP,      jmp: JMP_LOOP_END, target: STEP_EMIT};
      STEP_MUL:      w = '{op: DP_MUL,      jmp: JMP_PERM,     target: STEP_LOOP};
      STEP_DIV_INIT: w = '{op: DP_DIV_INIT, jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_DIV_STEP: w = '{op: DP_DIV_STEP, jmp: JMP_DIV_MORE, target: STEP_DIV_STEP};
      STEP_DIV_END:  w = '{op: DP_DIV_END,  jmp: JMP_ALWAYS,   target: STEP_LOOP};
      STEP_EMIT:     w = '{op: DP_EMIT,     jmp: JMP_OUT_BUSY, target: STEP_EMIT};
      default:       w = '{op: DP_NOP,      jmp: JMP_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> design/combination_permutation_unit.sv
// combination / permutation counter
// input channel (in_valid / in_ready) carries op, n and r; op 0 asks for
// n choose r, op 1 for n! / (n-r)!. the count comes back on the output
// channel (out_valid / out_ready) as an exact 62-bit value, zero when r > n
// or n is above MAX_N. one result per request, in order.
// control is a small microcode program stepping a multiply / divide datapath;
// one request is worked on at a time and in_ready is high only in the idle step.
// permutations take r factors and combinations k = min(r, n - r); an out-of-range
// request goes straight from the check to the emit step.
// each factor costs a loop test and a multiply step, and for combinations an
// exact divide by the step index that retires 4 quotient bits per cycle.
// the finished count moves to an output register and the block goes back to
// idle, so the next request can be taken while the count waits; if the receiver
// still holds the previous count, the block sits in the emit step until it goes.
// reset clears the step counter, the divider's digit counter and out_valid; nothing else is kept.
module combination_permutation_unit #(
  parameter int unsigned MAX_N = cmbperm_pkg::MAX_N
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [cmbperm_pkg::N_W-1:0]       n,
  input  logic [cmbperm_pkg::N_W-1:0]       r,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cmbperm_pkg::COUNT_W-1:0]   count
);

  cmbperm_pkg::uword_t     uword;
  cmbperm_pkg::dp_status_t status;

  cmbperm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uword  (uword)
  );

  cmbperm_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .uword     (uword),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .n         (n),
    .r         (r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .count     (count)
  );

endmodule

>>> design/cmbperm_seq.sv
module cmbperm_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  cmbperm_pkg::dp_status_t status,
  output cmbperm_pkg::uword_t     uword
);

  cmbperm_pkg::pc_t pc;
  cmbperm_pkg::pc_t pc_next;
  logic             take;

  assign uword = cmbperm_pkg::ucode(pc);

  always_comb begin
    case (uword.jmp)
      cmbperm_pkg::JMP_NEXT:     take = 1'b0;
      cmbperm_pkg::JMP_ALWAYS:   take = 1'b1;
      cmbperm_pkg::JMP_NO_REQ:   take = !status.req;
      cmbperm_pkg::JMP_BAD:      take = status.bad;
      cmbperm_pkg::JMP_LOOP_END: take = status.loop_end;
      cmbperm_pkg::JMP_PERM:     take = status.perm;
      cmbperm_pkg::JMP_DIV_MORE: take = status.div_more;
      cmbperm_pkg::JMP_OUT_BUSY: take = status.out_busy;
      default:                   take = 1'b0;
    endcase
  end

  // falling off the last step wraps back to idle
  always_comb begin
    if (take) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + cmbperm_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= cmbperm_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> design/cmbperm_div.sv
module cmbperm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic                            step,
  input  logic [cmbperm_pkg::DIV_W-1:0]   dividend,
  input  logic [cmbperm_pkg::N_W-1:0]     divisor,
  output logic [cmbperm_pkg::DIV_W-1:0]   quotient,
  output logic                            more
);

  logic [cmbperm_pkg::DIV_W-1:0]  quot;
  logic [cmbperm_pkg::N_W-1:0]    rem;
  logic [cmbperm_pkg::DCNT_W-1:0] dcnt;
  logic [cmbperm_pkg::DIV_W-1:0]  quot_next;
  logic [cmbperm_pkg::N_W-1:0]    rem_next;

  assign quotient = quot;
  assign more     = dcnt != cmbperm_pkg::DCNT_W'(cmbperm_pkg::DIV_STEPS - 1);

  // restoring division, one digit of DIGIT_W bits per step
  always_comb begin
    logic [cmbperm_pkg::N_W:0] part;
    quot_next = quot;
    rem_next  = rem;
    for (int b = 0; b < cmbperm_pkg::DIGIT_W; b++) begin
      part      = {rem_next, quot_next[cmbperm_pkg::DIV_W-1]};
      quot_next = {quot_next[cmbperm_pkg::DIV_W-2:0], 1'b0};
      if (part >= {1'b0, divisor}) begin
        part         = part - {1'b0, divisor};
        quot_next[0] = 1'b1;
      end
      rem_next = part[cmbperm_pkg::N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (load) begin
      dcnt <= '0;
    end else if (step) begin
      dcnt <= dcnt + cmbperm_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= dividend;
      rem  <= '0;
    end else if (step) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule

>>> design/cmbperm_dp.sv
module cmbperm_dp #(
  parameter int unsigned MAX_N = cmbperm_pkg::MAX_N
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmbperm_pkg::uword_t                uword,
  output cmbperm_pkg::dp_status_t            status,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [cmbperm_pkg::N_W-1:0]       n,
  input  logic [cmbperm_pkg::N_W-1:0]       r,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cmbperm_pkg::COUNT_W-1:0]   count
);

  logic                              perm;
  logic [cmbperm_pkg::N_W-1:0]       nv;
  logic [cmbperm_pkg::N_W-1:0]       rv;
  logic [cmbperm_pkg::N_W-1:0]       k;
  logic [cmbperm_pkg::N_W-1:0]       i;
  logic [cmbperm_pkg::COUNT_W-1:0]   acc;
  logic [cmbperm_pkg::N_W-1:0]       factor;
  logic [cmbperm_pkg::PROD_W-1:0]    prod;
  logic [cmbperm_pkg::N_W-1:0]       rest;
  logic                              bad;
  logic                              emit;
  logic [cmbperm_pkg::DIV_W-1:0]     quotient;
  logic                              div_more;

  assign in_ready = uword.op == cmbperm_pkg::DP_LOAD;
  assign bad      = nv > cmbperm_pkg::N_W'(MAX_N) || rv > nv;
  assign rest     = nv - rv;
  assign factor   = nv - i;
  assign prod     = cmbperm_pkg::PROD_W'(acc) * cmbperm_pkg::PROD_W'(factor);
  assign emit     = uword.op == cmbperm_pkg::DP_EMIT && (!out_valid || out_ready);

  assign status.req      = in_valid;
  assign status.bad      = bad;
  assign status.loop_end = i == k;
  assign status.perm     = perm;
  assign status.div_more = div_more;
  assign status.out_busy = out_valid && !out_ready;

  // divisor is i after the multiply step has bumped it, i.e. the old i + 1
  cmbperm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (uword.op == cmbperm_pkg::DP_DIV_INIT),
    .step     (uword.op == cmbperm_pkg::DP_DIV_STEP),
    .dividend (cmbperm_pkg::DIV_W'(acc)),
    .divisor  (i),
    .quotient (quotient),
    .more     (div_more)
  );

  always_ff @(posedge clk) begin
    case (uword.op)
      cmbperm_pkg::DP_LOAD: begin
        if (in_valid) begin
          perm <= op;
          nv   <= n;
          rv   <= r;
        end
      end
      cmbperm_pkg::DP_CHECK: begin
        i   <= '0;
        acc <= bad ? '0 : cmbperm_pkg::COUNT_W'(1);
        // combinations use the smaller of r and n - r
        if (perm || rv <= rest) begin
          k <= rv;
        end else begin
          k <= rest;
        end
      end
      cmbperm_pkg::DP_MUL: begin
        acc <= prod[cmbperm_pkg::COUNT_W-1:0];
        i   <= i + cmbperm_pkg::N_W'(1);
      end
      cmbperm_pkg::DP_DIV_END: begin
        acc <= quotient[cmbperm_pkg::COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      count <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
